// File: design/salwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwt_pkg
// Shared types and constants of the adaptive log write throttle.
// ----------------------------------------------------------------------------
package salwt_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COOLDOWN_NORMAL = 2'd0,
    CFG_COOLDOWN_STORM  = 2'd1,
    CFG_STORM_THRESHOLD = 2'd2
  } cfg_index_t;

  // field widths fixed by the interface
  localparam int TIME_W     = 32;
  localparam int CODE_W     = 8;
  localparam int COOLDOWN_W = 16;
  localparam int RATE_W     = 14;

  // register reset values
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_NORMAL_RST = 16'd1000;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_STORM_RST  = 16'd10000;
  localparam logic [RATE_W-1:0]     STORM_THRESHOLD_RST = 14'd5;

  // rate arithmetic
  localparam int RateScale = 1000;
  localparam logic [TIME_W-1:0] RATE_FIELD_MAX = 32'd10000;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DECIDE
  } state_t;

endpackage

// File: design/salwt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module salwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/salwt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwt_div
// Restoring divider: constant dividend over a 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module salwt_div
  import salwt_pkg::*;
#(
  parameter int DIVIDEND = 10000,
  parameter int QW       = $clog2(DIVIDEND + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [QW-1:0]     quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [QW-1:0]     quo;
  logic [CW-1:0]     count;
  logic              busy;
  logic [TIME_W:0]   trial;
  logic              ge;

  // one trial subtraction per cycle
  assign trial = {rem, quo[QW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(QW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= QW'(DIVIDEND);
    end else if (busy) begin
      rem <= ge ? TIME_W'(trial - {1'b0, dvs}) : trial[TIME_W-1:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// File: design/storm_adaptive_log_write_throttle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// storm_adaptive_log_write_throttle
// Rate-adaptive cooldown filter in front of a circular fault log.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one fault event (now_ms, fault_code) taken on the
//   in_valid/in_ready handshake. Every item produces exactly one result on
//   the out_valid/out_ready handshake: accept/throttle decision, log slot,
//   storm flag, computed rate, log occupancy, oldest slot, lifetime count.
//   Recent timestamps and per-code last write times live in two RAMs, read
//   once per item; each item is written to the window, and a logged in-range
//   code's time is written back. Valid flops make unwritten entries read as zero.
//   Timing: after an item is taken the sequencer goes through READ, then DIV
//   when the window rate is nonzero, where the bit-serial rate divider works
//   out the rate, then DECIDE, where the result is registered, and back to
//   IDLE before the next item is taken. One item is in work.
//   The result sits in an output register; the next item is accepted while
//   it waits, but its result is held back until the receiver takes the
//   previous one.
//   Reset (rst, synchronous) clears the window, per-code times, log counters
//   and restores register defaults. Registers are written (cfg_we/cfg_index/
//   cfg_data) by the user only while no item is in work; not enforced.
// ----------------------------------------------------------------------------
module storm_adaptive_log_write_throttle
  import salwt_pkg::*;
#(
  parameter int WINDOW    = 10,
  parameter int NUM_CODES = 32,
  parameter int LOG_DEPTH = 50,
  parameter int SW        = $clog2(LOG_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [CODE_W-1:0]     fault_code,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  accepted,
  output logic [SW-1:0]         write_slot,
  output logic                  storm,
  output logic [RATE_W-1:0]     fault_rate,
  output logic [SW-1:0]         entries_held,
  output logic [SW-1:0]         oldest_slot,
  output logic [TIME_W-1:0]     lifetime_total
);

  localparam int WAW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CAW      = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam int DIVIDEND = WINDOW * RateScale;
  localparam int QW       = $clog2(DIVIDEND + 1);

  // configuration registers
  logic [COOLDOWN_W-1:0] cooldown_normal;
  logic [COOLDOWN_W-1:0] cooldown_storm;
  logic [RATE_W-1:0]     storm_threshold;

  // sequencer
  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   div_start;
  logic   decide_go;

  // item registers
  logic [TIME_W-1:0] now_q;
  logic [CAW-1:0]    idx_q;
  logic              in_range_q;
  logic              oldest_vld_q;
  logic              lwt_vld_q;
  logic [QW-1:0]     quo_q;

  // window and per-code tables
  logic [WAW-1:0]    win_pos;
  logic [WAW-1:0]    win_pos_next;
  logic              win_vld [WINDOW];
  logic              lwt_vld [NUM_CODES];
  logic [TIME_W-1:0] win_rdata;
  logic [TIME_W-1:0] lwt_rdata;
  logic              in_range;
  logic [CAW-1:0]    code_idx;

  // log state
  logic [SW-1:0]     log_oldest;
  logic [SW-1:0]     log_count;
  logic [SW-1:0]     log_oldest_next;
  logic [SW-1:0]     log_count_next;
  logic [TIME_W-1:0] lifetime_count;

  // datapath
  logic [TIME_W-1:0]     oldest;
  logic [TIME_W-1:0]     span;
  logic                  zero_rate;
  logic                  div_done;
  logic [QW-1:0]         div_quo;
  logic [TIME_W-1:0]     rate32;
  logic                  storm_now;
  logic [COOLDOWN_W-1:0] cooldown;
  logic [TIME_W-1:0]     last_time;
  logic                  throttled;
  logic                  log_full;
  logic [SW:0]           slot_sum;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         oldest_inc;
  logic [RATE_W-1:0]     rate_sat;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_normal <= COOLDOWN_NORMAL_RST;
      cooldown_storm  <= COOLDOWN_STORM_RST;
      storm_threshold <= STORM_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_COOLDOWN_NORMAL: cooldown_normal <= cfg_data;
        CFG_COOLDOWN_STORM:  cooldown_storm  <= cfg_data;
        CFG_STORM_THRESHOLD: storm_threshold <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = zero_rate ? ST_DECIDE : ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_DECIDE;
      ST_DECIDE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    decide_go = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_READ:   div_start = !zero_rate;
      ST_DECIDE: decide_go = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_fire = in_valid && in_ready;

  // window push and lookup addresses
  assign win_pos_next = (win_pos == WAW'(WINDOW - 1)) ? '0 : win_pos + 1'b1;
  assign in_range     = {1'b0, fault_code} < (CODE_W + 1)'(NUM_CODES);
  assign code_idx     = in_range ? fault_code[CAW-1:0] : '0;

  salwt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WINDOW),
    .AW    (WAW)
  ) u_win_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (win_pos),
    .wdata (now_ms),
    .re    (in_fire),
    .raddr (win_pos_next),
    .rdata (win_rdata)
  );

  salwt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_CODES),
    .AW    (CAW)
  ) u_lwt_ram (
    .clk   (clk),
    .we    (decide_go && in_range_q && !throttled),
    .waddr (idx_q),
    .wdata (now_q),
    .re    (in_fire),
    .raddr (code_idx),
    .rdata (lwt_rdata)
  );

  // window state and valid flops
  always_ff @(posedge clk) begin
    if (rst) begin
      win_pos <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        win_vld[i] <= 1'b0;
      end
    end else if (in_fire) begin
      win_pos          <= win_pos_next;
      win_vld[win_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        lwt_vld[i] <= 1'b0;
      end
    end else if (decide_go && in_range_q && !throttled) begin
      lwt_vld[idx_q] <= 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_q        <= now_ms;
      idx_q        <= code_idx;
      in_range_q   <= in_range;
      oldest_vld_q <= win_vld[win_pos_next];
      lwt_vld_q    <= lwt_vld[code_idx];
    end
  end

  // span from the oldest window entry
  assign oldest    = oldest_vld_q ? win_rdata : '0;
  assign span      = now_q - oldest;
  assign zero_rate = (oldest == '0) || (span == '0);

  salwt_div #(
    .DIVIDEND (DIVIDEND),
    .QW       (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (state == ST_READ && zero_rate) begin
      quo_q <= '0;
    end else if (state == ST_DIV && div_done) begin
      quo_q <= div_quo;
    end
  end

  // storm and cooldown decision
  assign rate32    = TIME_W'(quo_q);
  assign storm_now = rate32 > TIME_W'(storm_threshold);
  assign cooldown  = storm_now ? cooldown_storm : cooldown_normal;
  assign last_time = lwt_vld_q ? lwt_rdata : '0;
  assign throttled = in_range_q && ((now_q - last_time) < TIME_W'(cooldown));
  assign rate_sat  = (rate32 > RATE_FIELD_MAX) ? RATE_FIELD_MAX[RATE_W-1:0]
                                               : rate32[RATE_W-1:0];

  // circular log slot selection
  assign log_full   = log_count >= SW'(LOG_DEPTH);
  assign slot_sum   = (SW + 1)'(log_oldest) + (SW + 1)'(log_count);
  assign oldest_inc = (log_oldest == SW'(LOG_DEPTH - 1)) ? '0 : log_oldest + 1'b1;

  always_comb begin
    slot            = '0;
    log_oldest_next = log_oldest;
    log_count_next  = log_count;
    if (!throttled) begin
      if (log_full) begin
        slot            = log_oldest;
        log_oldest_next = oldest_inc;
      end else begin
        slot           = (slot_sum >= (SW + 1)'(LOG_DEPTH))
                         ? SW'(slot_sum - (SW + 1)'(LOG_DEPTH)) : slot_sum[SW-1:0];
        log_count_next = log_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_oldest     <= '0;
      log_count      <= '0;
      lifetime_count <= '0;
    end else if (decide_go) begin
      log_oldest <= log_oldest_next;
      log_count  <= log_count_next;
      if (!throttled) begin
        lifetime_count <= lifetime_count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      accepted       <= !throttled;
      write_slot     <= slot;
      storm          <= storm_now;
      fault_rate     <= rate_sat;
      entries_held   <= log_count_next;
      oldest_slot    <= log_oldest_next;
      lifetime_total <= throttled ? lifetime_count : lifetime_count + 1'b1;
    end
  end

  // checks
  a_throttled_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> write_slot == '0)
    else $error("throttled item reports a nonzero slot");

  a_log_count_bound: assert property (@(posedge clk) disable iff (rst)
    log_count <= SW'(LOG_DEPTH) && log_oldest < SW'(LOG_DEPTH))
    else $error("log pointers out of range");

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_storm_matches_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && (RATE_W + 1)'(fault_rate) > (RATE_W + 1)'(storm_threshold) |-> storm)
    else $error("rate above threshold without storm");

endmodule

// File: test/tb_storm_adaptive_log_write_throttle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_storm_adaptive_log_write_throttle
// Self-checking bench for the rate-adaptive fault log write throttle.
// A queue of fault events feeds a valid/ready driver. Each accepted event runs
// through a local model of the window rate, the per-code cooldown and the
// circular log. Every result is checked field by field against that model.
// The run covers reset defaults, zero and full-scale cooldowns, masked
// threshold writes, wrapping timestamps, random stalls on both sides and
// one stretch with no stalls at all.
// ----------------------------------------------------------------------------
module tb_storm_adaptive_log_write_throttle;
  import salwt_pkg::*;

  localparam int unsigned WIN         = 10;
  localparam int unsigned CODES       = 32;
  localparam int unsigned DEPTH       = 50;
  localparam int          SLOT_W      = 6;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          SHOW_LIMIT  = 10;
  localparam logic [TIME_W-1:0] RATE_NUMERATOR = WIN * RateScale;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [CODE_W-1:0] code;
    logic              settle;
  } fault_event_t;

  typedef struct packed {
    logic              logged;
    logic [SLOT_W-1:0] slot;
    logic              hot;
    logic [RATE_W-1:0] rate;
    logic [SLOT_W-1:0] held;
    logic [SLOT_W-1:0] oldest;
    logic [TIME_W-1:0] total;
  } log_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     now_ms = '0;
  logic [CODE_W-1:0]     fault_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  accepted;
  logic [SLOT_W-1:0]     write_slot;
  logic                  storm;
  logic [RATE_W-1:0]     fault_rate;
  logic [SLOT_W-1:0]     entries_held;
  logic [SLOT_W-1:0]     oldest_slot;
  logic [TIME_W-1:0]     lifetime_total;

  storm_adaptive_log_write_throttle uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_ms        (now_ms),
    .fault_code    (fault_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .write_slot    (write_slot),
    .storm         (storm),
    .fault_rate    (fault_rate),
    .entries_held  (entries_held),
    .oldest_slot   (oldest_slot),
    .lifetime_total(lifetime_total)
  );

  // model state, starting from the reset values
  logic [TIME_W-1:0]     win_stamp [WIN]    = '{default: '0};
  int unsigned           win_pos            = 0;
  logic [TIME_W-1:0]     code_stamp [CODES] = '{default: '0};
  int unsigned           log_head           = 0;
  int unsigned           log_fill           = 0;
  logic [TIME_W-1:0]     total_written      = '0;
  logic [COOLDOWN_W-1:0] normal_hold        = COOLDOWN_NORMAL_RST;
  logic [COOLDOWN_W-1:0] storm_hold         = COOLDOWN_STORM_RST;
  logic [RATE_W-1:0]     storm_floor        = STORM_THRESHOLD_RST;

  fault_event_t pending_events [$];
  log_verdict_t expected_verdicts [$];
  fault_event_t next_event;
  log_verdict_t want;
  logic         steady = 1'b0;
  logic [TIME_W-1:0] stamp_clock = '0;
  int           mismatches = 0;
  int           events_sent = 0;
  int           results_seen = 0;
  int           logged_seen = 0;
  int           storm_seen = 0;
  int           cycle_count = 0;

  // window rate, cooldown decision and circular log for one fault event
  function automatic log_verdict_t predict_verdict(logic [TIME_W-1:0] stamp,
                                                   logic [CODE_W-1:0] code);
    log_verdict_t v;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] quotient;
    logic [TIME_W-1:0] gap;
    logic [COOLDOWN_W-1:0] hold_ms;
    v = '0;
    win_stamp[win_pos] = stamp;
    win_pos = (win_pos + 1) % WIN;
    oldest = win_stamp[win_pos];
    span = stamp - oldest;
    quotient = (oldest == '0 || span == '0) ? '0 : RATE_NUMERATOR / span;
    v.hot = quotient > storm_floor;
    hold_ms = v.hot ? storm_hold : normal_hold;
    v.logged = 1'b1;
    // codes past the table skip the cooldown
    if (code < CODES) begin
      gap = stamp - code_stamp[code];
      if (gap < hold_ms) v.logged = 1'b0;
      else code_stamp[code] = stamp;
    end
    if (v.logged) begin
      if (log_fill >= DEPTH) begin
        v.slot = SLOT_W'(log_head);
        log_head = (log_head + 1) % DEPTH;
      end else begin
        v.slot = SLOT_W'((log_head + log_fill) % DEPTH);
        log_fill++;
      end
      total_written++;
    end
    v.rate = (quotient > RATE_FIELD_MAX) ? RATE_W'(RATE_FIELD_MAX) : RATE_W'(quotient);
    v.held = SLOT_W'(log_fill);
    v.oldest = SLOT_W'(log_head);
    v.total = total_written;
    return v;
  endfunction

  task automatic compare_field(string name, logic [TIME_W-1:0] got,
                               logic [TIME_W-1:0] exp_val);
    if (got !== exp_val) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("result %0d: %s is %0d, expected %0d", results_seen, name, got, exp_val);
    end
  endtask

  // register write, mirrored into the model
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COOLDOWN_NORMAL) normal_hold = val;
    else if (idx == CFG_COOLDOWN_STORM) storm_hold = val;
    else if (idx == CFG_STORM_THRESHOLD) storm_floor = val[RATE_W-1:0];
  endtask

  task automatic add_event(logic [TIME_W-1:0] stamp, logic [CODE_W-1:0] code,
                           logic settle);
    fault_event_t ev;
    ev.stamp = stamp;
    ev.code = code;
    ev.settle = settle;
    pending_events.push_back(ev);
  endtask

  // mostly forward-moving time with bursts, a few jumps and zero stamps
  task automatic add_random_events(int count);
    int pick;
    logic [CODE_W-1:0] code;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) stamp_clock += $urandom_range(30);
      else if (pick < 70) stamp_clock += $urandom_range(400);
      else if (pick < 88) stamp_clock += $urandom_range(5000);
      else if (pick < 95) stamp_clock += $urandom_range(70000);
      else if (pick < 98) stamp_clock = $urandom();
      else stamp_clock = '0;
      pick = $urandom_range(99);
      if (pick < 45) code = CODE_W'($urandom_range(3));
      else if (pick < 85) code = CODE_W'($urandom_range(CODES - 1));
      else code = CODE_W'($urandom_range(255));
      add_event(stamp_clock, code, $urandom_range(49) == 0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_verdicts.size() != 0);
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // input driver: predicts each item as it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(predict_verdict(now_ms, fault_code));
        events_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() > 0 && (steady || $urandom_range(99) >= 26) &&
            !(pending_events[0].settle && expected_verdicts.size() > 0)) begin
          next_event = pending_events.pop_front();
          in_valid <= 1'b1;
          now_ms <= next_event.stamp;
          fault_code <= next_event.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("accepted", accepted, want.logged);
          compare_field("write_slot", write_slot, want.slot);
          compare_field("storm", storm, want.hot);
          compare_field("fault_rate", fault_rate, want.rate);
          compare_field("entries_held", entries_held, want.held);
          compare_field("oldest_slot", oldest_slot, want.oldest);
          compare_field("lifetime_total", lifetime_total, want.total);
          if (want.logged) logged_seen++;
          if (want.hot) storm_seen++;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 26);
    end
  end

  // stimulus phases
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset defaults, cooldown edges, wrap, bypass codes, storm onset
    add_event(32'h0000_0000, 8'd0, 1'b0);
    add_event(32'd999, 8'd1, 1'b0);
    add_event(32'd1000, 8'd2, 1'b0);
    add_event(32'd1000, 8'd2, 1'b0);
    add_event(32'd5, 8'd32, 1'b0);
    add_event(32'hFFFF_FFFF, 8'd255, 1'b0);
    add_event(32'hFFFF_FFFF, 8'd31, 1'b0);
    add_event(32'h0000_0100, 8'd31, 1'b1);
    for (int i = 0; i < 10; i++) add_event(32'h8000_0000, CODE_W'(3 + 37 * i), 1'b0);
    add_event(32'h8000_0001, 8'd34, 1'b0);
    add_event(32'h8000_0002, 8'd34, 1'b0);
    add_event(32'h8000_0003, 8'd34, 1'b0);
    add_event(32'h8000_05DC, 8'd3, 1'b0);
    add_event(32'h8000_0640, 8'd200, 1'b0);
    stamp_clock = 32'h8000_0640;
    wait_drained();

    // random traffic under the reset defaults
    add_random_events(250);
    wait_drained();

    // zero cooldowns, zero threshold, spare index ignored
    write_reg(CFG_COOLDOWN_NORMAL, 16'd0);
    write_reg(CFG_COOLDOWN_STORM, 16'd0);
    write_reg(CFG_STORM_THRESHOLD, 16'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    add_random_events(150);
    wait_drained();

    // full-scale cooldowns, threshold upper bits masked off, time near wrap
    write_reg(CFG_COOLDOWN_NORMAL, 16'hFFFF);
    write_reg(CFG_COOLDOWN_STORM, 16'hFFFF);
    write_reg(CFG_STORM_THRESHOLD, 16'hFFFF);
    stamp_clock = 32'hFFFF_F000;
    add_random_events(150);
    wait_drained();

    // no stalls on either side
    write_reg(CFG_COOLDOWN_NORMAL, 16'd200);
    write_reg(CFG_COOLDOWN_STORM, 16'd5000);
    write_reg(CFG_STORM_THRESHOLD, 16'd10000);
    steady = 1'b1;
    add_random_events(200);
    wait_drained();
    steady = 1'b0;

    // mid-range settings with a low storm threshold
    write_reg(CFG_COOLDOWN_NORMAL, 16'd50);
    write_reg(CFG_COOLDOWN_STORM, 16'd3000);
    write_reg(CFG_STORM_THRESHOLD, 16'd20);
    add_random_events(250);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_verdicts.size() != 0) mismatches++;
    $display("%0d fault events checked: %0d logged, %0d throttled, %0d under storm cooldown",
             results_seen, logged_seen, results_seen - logged_seen, storm_seen);
    $display("register settings covered zero, mid and full-scale cooldowns; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
